// File: rtl/iha_pkg.sv
// shared constants, coefficient table and control types for the allpass pair
package iha_pkg;

   localparam int SAMPLE_WIDTH_DEF       = 16;
   localparam int INTERNAL_WIDTH_DEF     = 20;
   localparam int SECTIONS_PER_CHAIN_DEF = 4;

   // squared coefficients are unsigned Q0.18
   localparam int COEF_FRAC  = 18;
   localparam int COEF_ROUND = 1 << (COEF_FRAC - 1);

   // round(c*c * 2^18) for each chain and section slot
   function automatic logic [COEF_FRAC-1:0] coef_lookup(input logic chain,
                                                        input logic [1:0] slot);
      logic [COEF_FRAC-1:0] a;
      a = '0;
      if (!chain) begin
         case (slot)
            2'd0:    a = 18'd125672;
            2'd1:    a = 18'd229695;
            2'd2:    a = 18'd256009;
            2'd3:    a = 18'd261489;
            default: a = '0;
         endcase
      end else begin
         case (slot)
            2'd0:    a = 18'd42404;
            2'd1:    a = 18'd192159;
            2'd2:    a = 18'd247818;
            2'd3:    a = 18'd259679;
            default: a = '0;
         endcase
      end
      return a;
   endfunction

   typedef struct packed {
      logic accept;    // take the input item, start at section 0
      logic rd_en;     // read history row at rd_addr
      logic mul_en;    // form x + y2 and multiply by the coefficient
      logic acc_en;    // round, subtract x2, saturate, write history
      logic load_out;  // move the finished result to the output register
   } iha_cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being taken
   } iha_status_type;

endpackage

// File: rtl/iha_req_if.sv
// input sample channel
interface iha_req_if #(
   parameter int SAMPLE_WIDTH = iha_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/iha_rsp_if.sv
// quadrature output channel
interface iha_rsp_if #(
   parameter int SAMPLE_WIDTH = iha_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sine_path;
   logic signed [SAMPLE_WIDTH-1:0] cosine_path;

   modport source (output valid, output sine_path, output cosine_path, input ready);
   modport sink   (input valid, input sine_path, input cosine_path, output ready);
endinterface

// File: rtl/iir_hilbert_allpass_pair.sv
// allpass pair Hilbert splitter: one item in, one quadrature pair out
// each item passes from accept through every section of both chains to the output register
// a new item is taken only after the previous one is done, set by one shared multiply-add
//   stepping through each section of both chains and one history memory port
// a waiting result sits in the output register while the sequencer is free again
// synchronous reset clears all section history, the sine delay and the output valid
module iir_hilbert_allpass_pair #(
   parameter int SAMPLE_WIDTH       = iha_pkg::SAMPLE_WIDTH_DEF,
   parameter int INTERNAL_WIDTH     = iha_pkg::INTERNAL_WIDTH_DEF,
   parameter int SECTIONS_PER_CHAIN = iha_pkg::SECTIONS_PER_CHAIN_DEF
) (
   input logic      clock,
   input logic      reset,
   iha_req_if.sink  req_if,
   iha_rsp_if.source rsp_if
);
   import iha_pkg::*;

   localparam int ADDR_WIDTH = $clog2(2 * SECTIONS_PER_CHAIN);

   iha_cmd_type           cmd;
   iha_status_type        status;
   logic [ADDR_WIDTH-1:0] sect;
   logic [ADDR_WIDTH-1:0] rd_addr;

   iha_ctrl #(
      .SECTIONS_PER_CHAIN (SECTIONS_PER_CHAIN),
      .ADDR_WIDTH         (ADDR_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd),
      .sect      (sect),
      .rd_addr   (rd_addr)
   );

   iha_datapath #(
      .SAMPLE_WIDTH       (SAMPLE_WIDTH),
      .INTERNAL_WIDTH     (INTERNAL_WIDTH),
      .SECTIONS_PER_CHAIN (SECTIONS_PER_CHAIN),
      .ADDR_WIDTH         (ADDR_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sect            (sect),
      .rd_addr         (rd_addr),
      .status          (status),
      .req_sample      (req_if.sample),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_sine_path   (rsp_if.sine_path),
      .rsp_cosine_path (rsp_if.cosine_path)
   );

endmodule

// File: rtl/iha_ctrl.sv
// sequencer stepping one shared multiply-add through all sections of both chains
module iha_ctrl #(
   parameter int SECTIONS_PER_CHAIN = iha_pkg::SECTIONS_PER_CHAIN_DEF,
   parameter int ADDR_WIDTH         = $clog2(2 * SECTIONS_PER_CHAIN)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  iha_pkg::iha_status_type status,
   output iha_pkg::iha_cmd_type    cmd,
   output logic [ADDR_WIDTH-1:0]   sect,
   output logic [ADDR_WIDTH-1:0]   rd_addr
);
   import iha_pkg::*;

   localparam logic [ADDR_WIDTH-1:0] LAST_SECT = ADDR_WIDTH'(2 * SECTIONS_PER_CHAIN - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_WIDTH-1:0] sect_ff, sect_in;

   always_comb begin
      state_in  = state_ff;
      sect_in   = sect_ff;
      cmd       = '0;
      rd_addr   = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cmd.rd_en  = 1'b1;
               sect_in    = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (sect_ff == LAST_SECT) begin
               state_in = ST_DONE;
            end else begin
               // prefetch the next section's history while this one is written
               cmd.rd_en = 1'b1;
               rd_addr   = sect_ff + ADDR_WIDTH'(1);
               sect_in   = sect_ff + ADDR_WIDTH'(1);
               state_in  = ST_MUL;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sect_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sect_ff  <= sect_in;
      end
   end

   assign sect = sect_ff;

endmodule

// File: rtl/iha_datapath.sv
// section history memory, shared multiply-add and output register
module iha_datapath #(
   parameter int SAMPLE_WIDTH       = iha_pkg::SAMPLE_WIDTH_DEF,
   parameter int INTERNAL_WIDTH     = iha_pkg::INTERNAL_WIDTH_DEF,
   parameter int SECTIONS_PER_CHAIN = iha_pkg::SECTIONS_PER_CHAIN_DEF,
   parameter int ADDR_WIDTH         = $clog2(2 * SECTIONS_PER_CHAIN)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  iha_pkg::iha_cmd_type           cmd,
   input  logic [ADDR_WIDTH-1:0]          sect,
   input  logic [ADDR_WIDTH-1:0]          rd_addr,
   output iha_pkg::iha_status_type        status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sine_path,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_cosine_path
);
   import iha_pkg::*;

   localparam int IW        = INTERNAL_WIDTH;
   localparam int SW        = SAMPLE_WIDTH;
   localparam int DEPTH     = 2 * SECTIONS_PER_CHAIN;
   localparam int ROW_WIDTH = 4 * IW;
   localparam int PW        = IW + COEF_FRAC + 2;
   localparam int EXT       = IW - SW;
   localparam logic [ADDR_WIDTH-1:0] CHAIN0_END = ADDR_WIDTH'(SECTIONS_PER_CHAIN - 1);
   localparam logic [ADDR_WIDTH-1:0] LAST_SECT  = ADDR_WIDTH'(DEPTH - 1);
   localparam logic signed [IW-1:0]  INT_MAX    = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0]  INT_MIN    = {1'b1, {(IW-1){1'b0}}};
   localparam logic signed [SW-1:0]  OUT_MAX    = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]  OUT_MIN    = {1'b1, {(SW-1){1'b0}}};

   // history row per section: {y2, y1, x2, x1}
   logic [ROW_WIDTH-1:0] hist_mem [DEPTH];
   logic [DEPTH-1:0]     row_valid_ff;
   logic [ROW_WIDTH-1:0] rd_row_ff;
   logic                 rd_valid_ff;
   logic [ROW_WIDTH-1:0] row;

   logic signed [IW-1:0]     x_ff, x_in;
   logic signed [SW-1:0]     sample_ff;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [SW-1:0]     sine_now_ff;
   logic signed [SW-1:0]     cos_now_ff;
   logic signed [SW-1:0]     sine_delay_ff;
   logic                     rsp_valid_ff;
   logic signed [SW-1:0]     rsp_sine_ff;
   logic signed [SW-1:0]     rsp_cos_ff;

   logic signed [IW-1:0]         x1, x2, y1, y2;
   logic signed [IW:0]           sum;
   logic signed [COEF_FRAC:0]    coef;
   logic                         chain;
   logic [31:0]                  slot_full;
   logic signed [PW-1:0]         rounded;
   logic signed [IW+1:0]         scaled;
   logic signed [IW+2:0]         diff;
   logic signed [IW-1:0]         y_sat;
   logic signed [SW-1:0]         y_out;
   logic signed [IW-1:0]         sample_ext;

   assign row = rd_valid_ff ? rd_row_ff : '0;
   assign x1  = row[IW-1:0];
   assign x2  = row[2*IW-1:IW];
   assign y1  = row[3*IW-1:2*IW];
   assign y2  = row[4*IW-1:3*IW];

   assign sample_ext = {{EXT{sample_ff[SW-1]}}, sample_ff};

   // coefficient slot wraps every four sections within a chain
   assign chain     = (sect > CHAIN0_END);
   assign slot_full = 32'(sect) - (chain ? 32'(SECTIONS_PER_CHAIN) : 32'd0);
   assign coef      = {1'b0, coef_lookup(chain, slot_full[1:0])};

   assign sum     = {x_ff[IW-1], x_ff} + {y2[IW-1], y2};
   assign prod_in = sum * coef;

   // round half up, then floor shift by the coefficient fraction
   assign rounded = prod_ff + PW'(COEF_ROUND);
   assign scaled  = rounded[PW-1:COEF_FRAC];
   assign diff    = {scaled[IW+1], scaled} - {{3{x2[IW-1]}}, x2};

   always_comb begin
      if ((&diff[IW+2:IW-1]) || !(|diff[IW+2:IW-1])) begin
         y_sat = diff[IW-1:0];
      end else if (diff[IW+2]) begin
         y_sat = INT_MIN;
      end else begin
         y_sat = INT_MAX;
      end
   end

   always_comb begin
      if ((&y_sat[IW-1:SW-1]) || !(|y_sat[IW-1:SW-1])) begin
         y_out = y_sat[SW-1:0];
      end else if (y_sat[IW-1]) begin
         y_out = OUT_MIN;
      end else begin
         y_out = OUT_MAX;
      end
   end

   always_comb begin
      x_in = x_ff;
      if (cmd.accept) begin
         x_in = {{EXT{req_sample[SW-1]}}, req_sample};
      end else if (cmd.acc_en) begin
         // second chain restarts from the input sample
         x_in = (sect == CHAIN0_END) ? sample_ext : y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         hist_mem[sect] <= {y1, y_sat, x1, x_ff};
      end
      if (cmd.rd_en) begin
         rd_row_ff   <= hist_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.acc_en) begin
         row_valid_ff[sect] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en && sect == CHAIN0_END) begin
         sine_now_ff <= y_out;
      end
      if (cmd.acc_en && sect == LAST_SECT) begin
         cos_now_ff <= y_out;
      end
      if (cmd.load_out) begin
         rsp_sine_ff <= sine_delay_ff;
         rsp_cos_ff  <= cos_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         sine_delay_ff <= '0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff  <= 1'b1;
            sine_delay_ff <= sine_now_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sine_path   = rsp_sine_ff;
   assign rsp_cosine_path = rsp_cos_ff;

endmodule
